// ----- rtl/core/ddhb_pkg.sv -----
// Shared constants, types and the joystick scaling table for the H-bridge PWM block.
package ddhb_pkg;

   // PWM period in counts, and the full-scale command magnitude
   localparam int PERIOD_COUNTS = 1000;
   localparam int CMD_MAX       = 1000;

   // Joystick scaling: deflection * JOY_SCALE_NUM / JOY_SCALE_DEN, truncated toward zero
   localparam int JOY_SCALE_NUM = 999;
   localparam int JOY_SCALE_DEN = 120;

   // Full 8-bit deflection scales to -1065 .. 1057, so one bit beyond 11 is needed
   localparam int JOY_W      = 8;
   localparam int JOY_CODES  = 1 << JOY_W;
   localparam int SCALED_W   = 12;
   localparam int SUM_W      = SCALED_W + 2;
   localparam int MAG_W      = $clog2(CMD_MAX + 1);
   localparam int PHASE_W    = (PERIOD_COUNTS > 2) ? $clog2(PERIOD_COUNTS) : 1;
   localparam int DUTY_W     = $clog2(CMD_MAX * PERIOD_COUNTS + 1);
   localparam int CHANNELS   = 4;

   localparam int REQ_DATA_W = 2 * JOY_W;
   localparam int RSP_DATA_W = 8;

   // Channel order in the pin vector
   localparam int CH_LEFT_FWD  = 0;
   localparam int CH_LEFT_REV  = 1;
   localparam int CH_RIGHT_FWD = 2;
   localparam int CH_RIGHT_REV = 3;

   // Request kinds carried on tuser
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_COMMAND = 1'b1;

   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef scaled_type scale_table_type [0:JOY_CODES-1];
   typedef logic [DUTY_W-1:0] duty_type;
   typedef duty_type [CHANNELS-1:0] duty_set_type;
   typedef logic [CHANNELS-1:0] pins_type;

   typedef struct packed {
      logic tick;
      logic load;
   } pwm_ctrl_type;

   function automatic scale_table_type build_scale_table();
      scale_table_type t;
      int v;
      for (int i = 0; i < JOY_CODES; i++) begin
         v = (i >= JOY_CODES / 2) ? i - JOY_CODES : i;
         t[i] = scaled_type'((v * JOY_SCALE_NUM) / JOY_SCALE_DEN);
      end
      return t;
   endfunction

   localparam scale_table_type SCALE_TABLE = build_scale_table();

endpackage

// ----- rtl/core/differential_drive_hbridge_pwm.sv -----
// Requests pass an input register, then a result register loaded once the output is free.
// Throughput: one request per cycle unless stalled; a full input register waits for rsp_tready.
// A tick request returns the new pin levels; a command request returns the current ones
// and its duties apply from the next tick on.
// Reset: synchronous, clears phase counter, duties, pin levels and both valid flags.
module differential_drive_hbridge_pwm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ddhb_pkg::REQ_DATA_W-1:0]   req_tdata,  // joy_x[7:0], joy_y[15:8]
   input  logic                              req_tuser,  // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ddhb_pkg::RSP_DATA_W-1:0]   rsp_tdata   // left_forward, left_reverse,
                                                         // right_forward, right_reverse,
                                                         // zero [7:4]
);
   import ddhb_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic               in_kind_ff, in_kind_in;
   logic [JOY_W-1:0]   in_x_ff, in_x_in;
   logic [JOY_W-1:0]   in_y_ff, in_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pins_type           rsp_pins_ff, rsp_pins_in;

   logic               out_free;
   logic               advance;
   logic               req_take;
   pwm_ctrl_type       ctrl;
   duty_set_type       duty_set;
   pins_type           pins_now;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign ctrl.tick = advance && (in_kind_ff == REQ_TICK);
   assign ctrl.load = advance && (in_kind_ff == REQ_COMMAND);

   ddhb_cmd u_cmd (
      .joy_x    (in_x_ff),
      .joy_y    (in_y_ff),
      .duty_set (duty_set)
   );

   ddhb_pwm u_pwm (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .duty_set (duty_set),
      .pins_out (pins_now)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_x_in     = in_x_ff;
      in_y_in     = in_y_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser;
         in_x_in     = req_tdata[JOY_W-1:0];
         in_y_in     = req_tdata[2*JOY_W-1:JOY_W];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pins_in  = rsp_pins_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_pins_in  = pins_now;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      in_kind_ff  <= in_kind_in;
      in_x_ff     <= in_x_in;
      in_y_ff     <= in_y_in;
      rsp_pins_ff <= rsp_pins_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CHANNELS)'(0), rsp_pins_ff};

endmodule

// ----- rtl/core/ddhb_cmd.sv -----
// Joystick command decode: axis scaling, mixing, saturation and duty thresholds.
module ddhb_cmd (
   input  logic [ddhb_pkg::JOY_W-1:0] joy_x,
   input  logic [ddhb_pkg::JOY_W-1:0] joy_y,
   output ddhb_pkg::duty_set_type     duty_set
);
   import ddhb_pkg::*;

   scaled_type           x_speed;
   scaled_type           y_speed;
   logic signed [SUM_W-1:0] left_cmd;
   logic signed [SUM_W-1:0] right_cmd;
   duty_type             left_duty;
   duty_type             right_duty;

   // Saturated magnitude times the period; compared later against (phase+1)*CMD_MAX
   function automatic duty_type to_duty(logic signed [SUM_W-1:0] cmd);
      logic [SUM_W-1:0] mag;
      logic [MAG_W-1:0] sat;
      mag = cmd[SUM_W-1] ? SUM_W'(-cmd) : SUM_W'(cmd);
      sat = (mag > SUM_W'(CMD_MAX)) ? MAG_W'(CMD_MAX) : mag[MAG_W-1:0];
      return DUTY_W'(sat) * DUTY_W'(PERIOD_COUNTS);
   endfunction

   assign x_speed   = SCALE_TABLE[joy_x];
   assign y_speed   = SCALE_TABLE[joy_y];
   assign left_cmd  = SUM_W'(x_speed) + SUM_W'(y_speed);
   assign right_cmd = SUM_W'(x_speed) - SUM_W'(y_speed);

   assign left_duty  = to_duty(left_cmd);
   assign right_duty = to_duty(right_cmd);

   always_comb begin
      duty_set = '0;
      if (left_cmd > 0) begin
         duty_set[CH_LEFT_FWD] = left_duty;
      end else if (left_cmd < 0) begin
         duty_set[CH_LEFT_REV] = left_duty;
      end
      if (right_cmd > 0) begin
         duty_set[CH_RIGHT_FWD] = right_duty;
      end else if (right_cmd < 0) begin
         duty_set[CH_RIGHT_REV] = right_duty;
      end
   end

endmodule

// ----- rtl/core/ddhb_pwm.sv -----
// PWM core: phase counter, per-channel duty registers and pin level register.
module ddhb_pwm (
   input  logic                    clock,
   input  logic                    reset,
   input  ddhb_pkg::pwm_ctrl_type  ctrl,
   input  ddhb_pkg::duty_set_type  duty_set,
   output ddhb_pkg::pins_type      pins_out
);
   import ddhb_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   duty_set_type       duty_ff, duty_in;
   pins_type           pins_ff, pins_in;
   logic [PHASE_W:0]   phase_next;
   duty_type           threshold;
   logic               last_phase;
   pins_type           pins_tick;

   assign phase_next = {1'b0, phase_ff} + 1'b1;
   assign threshold  = DUTY_W'(phase_next) * DUTY_W'(CMD_MAX);
   assign last_phase = (phase_ff == PHASE_W'(PERIOD_COUNTS - 1));

   // Compare is capped at period-1, so nothing stays high on the last phase
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         pins_tick[i] = !last_phase && (duty_ff[i] >= threshold);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      duty_in  = duty_ff;
      pins_in  = pins_ff;
      if (ctrl.tick) begin
         pins_in  = pins_tick;
         phase_in = last_phase ? '0 : phase_next[PHASE_W-1:0];
      end
      if (ctrl.load) begin
         duty_in = duty_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         duty_ff  <= '0;
         pins_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         duty_ff  <= duty_in;
         pins_ff  <= pins_in;
      end
   end

   assign pins_out = pins_in;

endmodule

// ----- rtl/core/ddhb_checker.sv -----
// Port-level checker for the H-bridge PWM block, bound to the top level.
module ddhb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ddhb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ddhb_pkg::*;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No shoot-through: forward and reverse of one motor are never driven together
   a_no_shoot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[CH_LEFT_FWD] && rsp_tdata[CH_LEFT_REV])
                  && !(rsp_tdata[CH_RIGHT_FWD] && rsp_tdata[CH_RIGHT_REV]))
      else $error("both pins of one bridge high");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:CHANNELS] == '0)
      else $error("padding bits of response not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind differential_drive_hbridge_pwm ddhb_checker u_ddhb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
